FILE: src/blpb_pkg.sv
package blpb_pkg;

    localparam int LVL_W   = 16;
    localparam int HOLD_W  = 18;
    localparam int SPEED_W = 24;
    localparam int IDX_W   = 5;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 18;

    localparam logic [LVL_W-1:0]   FULL_SCALE = 16'd32768;
    localparam logic [SPEED_W-1:0] FALL_MAX   = 24'hFF_FFFF;
    localparam logic [16:0]        ROUND_HALF = 17'd32768;

    localparam logic [CFG_AW-1:0] CFG_ATTACK = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_DECAY  = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_HOLD   = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_BASE   = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_ACCEL  = 3'd4;

    localparam logic [15:0] ATTACK_RST = 16'd39322;
    localparam logic [15:0] DECAY_RST  = 16'd9830;
    localparam logic [16:0] HOLD_RST   = 17'd32768;
    localparam logic [17:0] BASE_RST   = 18'd29491;
    localparam logic [17:0] ACCEL_RST  = 18'd72090;

    localparam logic OP_LEVEL = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_MUL1,
        S_UPD,
        S_MUL2,
        S_WB
    } t_state;

    typedef struct packed {
        logic [SPEED_W-1:0] fall_speed;
        logic [HOLD_W-1:0]  hold;
        logic [LVL_W-1:0]   peak;
        logic [LVL_W-1:0]   level;
    } t_entry;

endpackage

FILE: src/blpb_ram.sv
module blpb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/bar_level_peak_ballistics_top.sv
// Channel    | Direction | Handshake                     | Payload
// s_axis     | in        | s_axis_tvalid / s_axis_tready | tdata: bar, target, elapsed; tuser: op
// m_axis     | out       | m_axis_tvalid / m_axis_tready | tdata: bar, bar level, peak level
// cfg        | in        | i_cfg_we                      | i_cfg_addr, i_cfg_data
//
// One request is processed at a time through a read-modify-write pass on the bar memory.
// Level requests and ticks inside the hold time pass through load, multiply, update and write-back;
// a falling-peak tick adds a second multiply; an out-of-range bar goes straight to write-back.
// The next request is accepted in the cycle after write-back, even while the result waits.
// Reset clears all bar state at once through per-bar valid bits; no clearing pass is needed.
// A stalled output holds the block in write-back until the result register frees up.
module bar_level_peak_ballistics_top
    import blpb_pkg::*;
#(
    parameter int NUM_BARS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [39:0]       s_axis_tdata,  // bar_index[4:0], target_level[20:5], elapsed_time[36:21]
    input  logic              s_axis_tuser,  // op[0]
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [39:0]       m_axis_tdata,  // out_bar[4:0], bar_level[20:5], peak_level[36:21]
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    localparam int AW = (NUM_BARS > 1) ? $clog2(NUM_BARS) : 1;
    localparam int EW = $bits(t_entry);

    t_state r_state, n_state;

    logic [15:0] r_attack, r_decay;
    logic [16:0] r_hold_time;
    logic [17:0] r_base, r_accel;

    logic [NUM_BARS-1:0] r_valid;
    logic                r_rd_valid;

    logic               r_op;
    logic [IDX_W-1:0]   r_idx;
    logic [LVL_W-1:0]   r_tgt;
    logic [15:0]        r_dt;
    logic               r_oob;
    logic [LVL_W-1:0]   r_lvl, r_pk;
    logic [HOLD_W-1:0]  r_hold;
    logic [SPEED_W-1:0] r_fs;
    logic [LVL_W-1:0]   r_diff;
    logic               r_up;
    logic [33:0]        r_prod;
    logic [40:0]        r_prod2;

    logic               r_out_valid;
    logic [IDX_W-1:0]   r_out_bar;
    logic [LVL_W-1:0]   r_out_lvl, r_out_pk;

    logic           w_accept, w_in_range, w_ram_re, w_ram_we, w_load_out;
    logic [AW-1:0]  w_in_addr, w_addr;
    logic [EW-1:0]  w_rdata;
    t_entry         w_entry, w_wb;
    logic [LVL_W-1:0] w_tgt_sat;
    logic [17:0]    w_mul_a;
    logic [15:0]    w_mul_b;
    logic [34:0]    w_rnd1;
    logic [24:0]    w_speed;
    logic [41:0]    w_rnd2;
    logic [25:0]    w_drop;
    logic [LVL_W-1:0] w_pk_less;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_in_range = 32'(s_axis_tdata[IDX_W-1:0]) < 32'(NUM_BARS);
    assign w_in_addr  = AW'(s_axis_tdata[IDX_W-1:0]);
    assign w_addr     = AW'(r_idx);
    assign w_ram_re   = w_accept && w_in_range;
    assign w_load_out = (r_state == S_WB) && (!r_out_valid || m_axis_tready);
    assign w_ram_we   = w_load_out && !r_oob;

    blpb_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_BARS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_addr),
        .i_wdata (w_wb),
        .i_re    (w_ram_re),
        .i_raddr (w_in_addr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack    <= ATTACK_RST;
            r_decay     <= DECAY_RST;
            r_hold_time <= HOLD_RST;
            r_base      <= BASE_RST;
            r_accel     <= ACCEL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_ATTACK: r_attack    <= i_cfg_data[15:0];
                CFG_DECAY:  r_decay     <= i_cfg_data[15:0];
                CFG_HOLD:   r_hold_time <= i_cfg_data[16:0];
                CFG_BASE:   r_base      <= i_cfg_data;
                CFG_ACCEL:  r_accel     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = w_in_range ? S_LOAD : S_WB;
                end
            end
            S_LOAD: n_state = S_MUL1;
            S_MUL1: n_state = S_UPD;
            S_UPD:  n_state = (r_op == OP_TICK && r_hold == '0) ? S_MUL2 : S_WB;
            S_MUL2: n_state = S_WB;
            S_WB: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_entry   = r_rd_valid ? t_entry'(w_rdata) : '0;
        w_tgt_sat = (r_tgt > FULL_SCALE) ? FULL_SCALE : r_tgt;
        w_mul_a   = (r_op == OP_TICK) ? r_accel : {2'b00, (r_up ? r_attack : r_decay)};
        w_mul_b   = (r_op == OP_TICK) ? r_dt : r_diff;
        w_rnd1    = 35'(r_prod) + 35'(ROUND_HALF);
        w_speed   = 25'(r_fs) + 25'(w_rnd1[34:16]);
        w_rnd2    = 42'(r_prod2) + 42'(ROUND_HALF);
        w_drop    = w_rnd2[41:16];
        w_pk_less = r_pk - w_drop[15:0];

        w_wb.level      = r_lvl;
        w_wb.peak       = r_pk;
        w_wb.hold       = r_hold;
        w_wb.fall_speed = r_fs;
        if (r_op == OP_LEVEL) begin
            if (r_lvl >= r_pk) begin
                w_wb.peak       = r_lvl;
                w_wb.hold       = 18'(r_hold_time);
                w_wb.fall_speed = '0;
            end
        end else if (r_hold != '0) begin
            w_wb.hold = (r_hold > 18'(r_dt)) ? r_hold - 18'(r_dt) : '0;
        end else if ((w_drop >= 26'(r_pk)) || (w_pk_less < r_lvl)) begin
            w_wb.peak = r_lvl;
        end else begin
            w_wb.peak = w_pk_less;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op       <= s_axis_tuser;
            r_idx      <= s_axis_tdata[4:0];
            r_tgt      <= s_axis_tdata[20:5];
            r_dt       <= s_axis_tdata[36:21];
            r_oob      <= !w_in_range;
            r_rd_valid <= w_in_range && r_valid[w_in_addr];
        end
        unique case (r_state)
            S_LOAD: begin
                r_lvl  <= w_entry.level;
                r_pk   <= w_entry.peak;
                r_hold <= w_entry.hold;
                r_fs   <= w_entry.fall_speed;
                r_up   <= w_tgt_sat > w_entry.level;
                r_diff <= (w_tgt_sat > w_entry.level) ? w_tgt_sat - w_entry.level
                                                       : w_entry.level - w_tgt_sat;
            end
            S_MUL1: r_prod <= 34'(w_mul_a) * 34'(w_mul_b);
            S_UPD: begin
                if (r_op == OP_LEVEL) begin
                    r_lvl <= r_up ? r_lvl + w_rnd1[31:16] : r_lvl - w_rnd1[31:16];
                end else if (r_hold == '0) begin
                    r_fs <= w_speed[24] ? FALL_MAX : w_speed[23:0];
                end
            end
            S_MUL2: r_prod2 <= 41'(25'(r_base) + 25'(r_fs)) * 41'(r_dt);
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_ram_we) begin
            r_valid[w_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_bar <= r_idx;
            r_out_lvl <= r_oob ? '0 : w_wb.level;
            r_out_pk  <= r_oob ? '0 : w_wb.peak;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_pk, r_out_lvl, r_out_bar};

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !s_axis_tready)
        else $error("request accepted while another is in flight");

    a_write_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> (r_state == S_WB) && w_load_out)
        else $error("bar memory written outside write-back");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_lvl <= FULL_SCALE) && (r_out_pk <= FULL_SCALE))
        else $error("result level above full scale");

    a_peak_above_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_pk >= r_out_lvl)
        else $error("peak marker below bar level");

    a_oob_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_in_range) |=> (r_state == S_WB) && r_oob)
        else $error("out-of-range bar did not bypass the memory");

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import blpb_pkg::*;

    localparam int BAR_COUNT   = 32;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [LVL_W-1:0] peak;
        logic [LVL_W-1:0] level;
        logic [IDX_W-1:0] bar;
    } t_meter_reading;

    class meter_scoreboard;
        logic [15:0]        attack_coef;
        logic [15:0]        decay_coef;
        logic [16:0]        hold_time;
        logic [17:0]        base_fall_rate;
        logic [17:0]        fall_accel;
        logic [LVL_W-1:0]   level_mem [BAR_COUNT];
        logic [LVL_W-1:0]   peak_mem [BAR_COUNT];
        logic [HOLD_W-1:0]  hold_mem [BAR_COUNT];
        logic [SPEED_W-1:0] speed_mem [BAR_COUNT];
        t_meter_reading     expected_readings [$];
        int                 errors;
        int                 level_count;
        int                 tick_count;
        int                 checked;

        function new();
            attack_coef    = ATTACK_RST;
            decay_coef     = DECAY_RST;
            hold_time      = HOLD_RST;
            base_fall_rate = BASE_RST;
            fall_accel     = ACCEL_RST;
            for (int i = 0; i < BAR_COUNT; i++) begin
                level_mem[i] = '0;
                peak_mem[i]  = '0;
                hold_mem[i]  = '0;
                speed_mem[i] = '0;
            end
            errors      = 0;
            level_count = 0;
            tick_count  = 0;
            checked     = 0;
        endfunction

        function void set_register(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
            case (idx)
                CFG_ATTACK: attack_coef    = val[15:0];
                CFG_DECAY:  decay_coef     = val[15:0];
                CFG_HOLD:   hold_time      = val[16:0];
                CFG_BASE:   base_fall_rate = val[17:0];
                CFG_ACCEL:  fall_accel     = val[17:0];
                default: ;
            endcase
        endfunction

        function t_meter_reading advance_bar(logic op, logic [IDX_W-1:0] bar,
                                             logic [15:0] target, logic [15:0] dt);
            logic [63:0]    tgt;
            logic [63:0]    lvl;
            logic [63:0]    pk;
            logic [63:0]    step;
            logic [63:0]    inc;
            logic [63:0]    speed;
            logic [63:0]    drop;
            t_meter_reading r;
            r.bar = bar;
            if (int'(bar) >= BAR_COUNT) begin
                r.level = '0;
                r.peak  = '0;
                return r;
            end
            lvl = 64'(level_mem[bar]);
            pk  = 64'(peak_mem[bar]);
            if (op == OP_LEVEL) begin
                tgt = (target > FULL_SCALE) ? 64'(FULL_SCALE) : 64'(target);
                if (tgt > lvl) begin
                    step = (64'(attack_coef) * (tgt - lvl) + 64'(ROUND_HALF)) >> 16;
                    lvl  = lvl + step;
                end else begin
                    step = (64'(decay_coef) * (lvl - tgt) + 64'(ROUND_HALF)) >> 16;
                    lvl  = lvl - step;
                end
                level_mem[bar] = lvl[LVL_W-1:0];
                if (lvl >= pk) begin
                    peak_mem[bar]  = lvl[LVL_W-1:0];
                    hold_mem[bar]  = HOLD_W'(hold_time);
                    speed_mem[bar] = '0;
                end
            end else if (hold_mem[bar] != 0) begin
                hold_mem[bar] = (hold_mem[bar] > dt) ? hold_mem[bar] - dt : '0;
            end else begin
                inc   = (64'(fall_accel) * 64'(dt) + 64'(ROUND_HALF)) >> 16;
                speed = 64'(speed_mem[bar]) + inc;
                if (speed > 64'(FALL_MAX)) begin
                    speed = 64'(FALL_MAX);
                end
                speed_mem[bar] = speed[SPEED_W-1:0];
                drop = ((64'(base_fall_rate) + speed) * 64'(dt) + 64'(ROUND_HALF)) >> 16;
                if (drop >= pk || pk - drop < lvl) begin
                    peak_mem[bar] = lvl[LVL_W-1:0];
                end else begin
                    peak_mem[bar] = LVL_W'(pk - drop);
                end
            end
            r.level = level_mem[bar];
            r.peak  = peak_mem[bar];
            return r;
        endfunction

        function void note_request(logic op, logic [IDX_W-1:0] bar,
                                   logic [15:0] target, logic [15:0] dt);
            if (op == OP_LEVEL) begin
                level_count++;
            end else begin
                tick_count++;
            end
            expected_readings.push_back(advance_bar(op, bar, target, dt));
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [39:0] data);
            t_meter_reading want;
            if (expected_readings.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, data);
                errors++;
                return;
            end
            want = expected_readings.pop_front();
            checked++;
            compare_field("out_bar", want.bar, data[4:0]);
            compare_field("bar_level", want.level, data[20:5]);
            compare_field("peak_level", want.peak, data[36:21]);
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction
    endclass

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [39:0]       s_axis_tdata  = '0;
    logic              s_axis_tuser  = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [39:0]       m_axis_tdata;
    logic              i_cfg_we      = 1'b0;
    logic [CFG_AW-1:0] i_cfg_addr    = '0;
    logic [CFG_DW-1:0] i_cfg_data    = '0;

    meter_scoreboard meter;
    bit              idle_on        = 1'b1;
    int              rx_hold_cycles = 0;
    int              settings_used  = 1;

    always #2 i_clk = ~i_clk;

    bar_level_peak_ballistics_top #(
        .NUM_BARS(BAR_COUNT)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data)
    );

    function automatic logic [15:0] random_target();
        if ($urandom_range(0, 9) == 0) begin
            return 16'($urandom_range(0, 65535));
        end
        return 16'($urandom_range(0, 32768));
    endfunction

    function automatic logic [15:0] random_dt();
        if ($urandom_range(0, 9) == 0) begin
            return 16'($urandom_range(0, 65535));
        end
        return 16'($urandom_range(0, 2184));
    endfunction

    task automatic send_request(input logic op, input logic [IDX_W-1:0] bar,
                                input logic [15:0] target, input logic [15:0] dt);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {3'b000, dt, target, bar};
        do @(posedge i_clk); while (!s_axis_tready);
        meter.note_request(op, bar, target, dt);
    endtask

    task automatic random_frames(input int count);
        int              sent;
        logic [IDX_W-1:0] bar;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 9) < 6) begin
                bar = IDX_W'($urandom_range(0, 3));
            end else begin
                bar = IDX_W'($urandom_range(0, BAR_COUNT - 1));
            end
            if ($urandom_range(0, 4) == 0) begin
                send_request(1'($urandom), bar, random_target(), random_dt());
                sent++;
            end else begin
                send_request(OP_LEVEL, bar, random_target(), random_dt());
                send_request(OP_TICK, bar, random_target(), random_dt());
                sent += 2;
            end
        end
    endtask

    task automatic write_register(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        meter.set_register(idx, val);
    endtask

    task automatic program_meter(input logic [15:0] attack, input logic [15:0] decay,
                                 input logic [16:0] hold, input logic [17:0] base,
                                 input logic [17:0] accel);
        s_axis_tvalid <= 1'b0;
        while (meter.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        write_register(CFG_ATTACK, CFG_DW'(attack));
        write_register(CFG_DECAY, CFG_DW'(decay));
        write_register(CFG_HOLD, CFG_DW'(hold));
        write_register(CFG_BASE, base);
        write_register(CFG_ACCEL, accel);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            meter.check_result(m_axis_tdata);
        end
    end

    initial begin : result_sink
        int gap;
        int hold;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold_cycles > 0) begin
                hold = rx_hold_cycles;
                rx_hold_cycles = 0;
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            gap = idle_on ? $urandom_range(0, 3) : 0;
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        int i;
        meter = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Rise toward full scale, then a target above full scale that must saturate.
        send_request(OP_LEVEL, 5'd0, 16'd32768, 16'($urandom));
        send_request(OP_LEVEL, 5'd0, 16'hFFFF, 16'($urandom));
        send_request(OP_LEVEL, 5'd0, 16'd0, 16'($urandom));
        // Hold countdown, including a tick longer than the remaining hold.
        send_request(OP_TICK, 5'd0, 16'($urandom), 16'd0);
        send_request(OP_TICK, 5'd0, 16'($urandom), 16'd1000);
        send_request(OP_TICK, 5'd0, 16'($urandom), 16'hFFFF);
        // Falling peak, first partially and then clamped to the bar level.
        send_request(OP_TICK, 5'd0, 16'($urandom), 16'd1092);
        send_request(OP_TICK, 5'd0, 16'($urandom), 16'd1092);
        send_request(OP_TICK, 5'd0, 16'($urandom), 16'hFFFF);
        send_request(OP_LEVEL, 5'd31, 16'd0, 16'($urandom));
        send_request(OP_LEVEL, 5'd31, 16'd32768, 16'($urandom));
        send_request(OP_LEVEL, 5'd31, 16'd0, 16'($urandom));
        send_request(OP_TICK, 5'd31, 16'($urandom), 16'hFFFF);
        send_request(OP_TICK, 5'd31, 16'($urandom), 16'hFFFF);
        send_request(OP_LEVEL, 5'd5, 16'd16384, 16'($urandom));
        send_request(OP_LEVEL, 5'd5, 16'd16384, 16'($urandom));
        send_request(OP_TICK, 5'd5, 16'hFFFF, 16'hFFFF);
        random_frames(100);

        // Largest settings, with enough ticks to saturate the fall speed.
        program_meter(16'hFFFF, 16'hFFFF, 17'h1FFFF, 18'h3FFFF, 18'h3FFFF);
        idle_on = 1'b0;
        send_request(OP_LEVEL, 5'd2, 16'd32768, 16'($urandom));
        repeat (70) send_request(OP_TICK, 5'd2, 16'($urandom), 16'hFFFF);
        send_request(OP_LEVEL, 5'd2, 16'd0, 16'($urandom));
        random_frames(60);
        idle_on = 1'b1;

        program_meter('0, '0, '0, '0, '0);
        random_frames(40);

        for (i = 0; i < 3; i++) begin
            program_meter(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                          17'($urandom_range(0, 131071)), 18'($urandom_range(0, 262143)),
                          18'($urandom_range(0, 262143)));
            if (i == 0) begin
                rx_hold_cycles = 300;
            end
            random_frames(70);
        end

        s_axis_tvalid <= 1'b0;
        while (meter.pending() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        $display("Covered %0d level and %0d tick requests over %0d register settings.",
                 meter.level_count, meter.tick_count, settings_used);
        $display("Checked %0d results, %0d mismatches.", meter.checked, meter.errors);
        if (meter.errors == 0 && meter.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
